>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion macros shared by the RTL of the surface fraction unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PSF_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define PSF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// Surface fraction package
// Constants and transfer types shared by the surface fraction unit.
// ----------------------------------------------------------------------------
package psf_pkg;

  localparam int MAX_LABELS    = 64;
  localparam int LABEL_BITS    = $clog2(MAX_LABELS);
  localparam int CFG_BITS      = 7;
  localparam int COUNT_BITS    = 32;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_OUT_BITS = FRACTION_BITS + 1;
  localparam int MARK_BITS     = 8;
  localparam int TOTAL_OUT_BITS = 32;

  typedef struct packed {
    logic [LABEL_BITS-1:0]       feature_label;
    logic signed [MARK_BITS-1:0] surface_mark;
    logic                        last_voxel;
  } in_item_t;

  typedef struct packed {
    logic [LABEL_BITS-1:0]     label_index;
    logic [FRAC_OUT_BITS-1:0]  surface_fraction;
    logic [TOTAL_OUT_BITS-1:0] voxel_total;
    logic                      empty_label;
    logic                      last_result;
  } out_item_t;

endpackage

>>> rtl/per_label_surface_fraction_unit.sv
// ----------------------------------------------------------------------------
// Per-label surface fraction unit
// Counts labelled voxels and positive surface marks per label in two count
// memories, then reads out the surface fraction of every active label but
// label 0 on the last voxel of a volume and clears the counts.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload      Handshake
//   in       input      in_item_t    in_valid / in_stall
//   out      output     out_item_t   out_valid / out_stall
//   cfg      input      label_count  cfg_we (write only)
//
// Counting takes one voxel transfer per cycle while input is not stalled: a
// registered read, a write-back in the next cycle, and forwarding when two
// successive voxels share a label. Each reported label passes a read, a divider
// start, 16 divider steps (none if empty or all surface), done and transfer.
// Input is stalled from the cycle after the last voxel until the last result,
// which holds in the output register while stalled; reset and readout clear
// the valid bits at once, so the count memories need no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module per_label_surface_fraction_unit
  import psf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_data
);

  // Sequencer codes.
  localparam logic [2:0] ST_COUNT = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [2:0]            state;
  logic [CFG_BITS-1:0]   label_count;
  logic [LABEL_BITS:0]   n_eff;
  logic [LABEL_BITS-1:0] k;

  // Count memories and their valid bits.
  logic [COUNT_BITS-1:0] total_mem   [MAX_LABELS];
  logic [COUNT_BITS-1:0] surface_mem [MAX_LABELS];
  logic [MAX_LABELS-1:0] vbits;
  logic [COUNT_BITS-1:0] rd_total;
  logic [COUNT_BITS-1:0] rd_surface;
  logic                  rd_vld;
  logic                  rd_en;
  logic [LABEL_BITS-1:0] rd_addr;

  // Write-back stage and forwarding path.
  logic                  s1_valid;
  logic [LABEL_BITS-1:0] s1_label;
  logic                  s1_surf;
  logic                  s1_count_en;
  logic                  s1_last;
  logic                  hit;
  logic [COUNT_BITS-1:0] fwd_total;
  logic [COUNT_BITS-1:0] fwd_surface;

  logic [COUNT_BITS-1:0] cur_total;
  logic [COUNT_BITS-1:0] cur_surface;
  logic [COUNT_BITS-1:0] new_total;
  logic [COUNT_BITS-1:0] new_surface;
  logic                  mem_we;
  logic                  in_accept;
  logic                  clear_all;
  logic                  k_is_last;

  logic                     div_start;
  logic                     div_done;
  logic [FRAC_OUT_BITS-1:0] div_quotient;

  // Label counts above the store depth behave as the full depth.
  assign n_eff = (label_count > CFG_BITS'(MAX_LABELS)) ? (LABEL_BITS+1)'(MAX_LABELS)
                                                       : (LABEL_BITS+1)'(label_count);

  assign in_stall  = (state != ST_COUNT) || (s1_valid && s1_last);
  assign in_accept = in_valid && !in_stall;

  // The memory port serves voxels while counting and labels during readout.
  assign rd_en   = in_accept || (state == ST_READ);
  assign rd_addr = (state == ST_COUNT) ? in_data.feature_label : k;

  // An entry never written since the last clear reads as zero; a voxel
  // following one of the same label takes the value about to be written.
  assign cur_total   = hit ? fwd_total   : (rd_vld ? rd_total   : '0);
  assign cur_surface = hit ? fwd_surface : (rd_vld ? rd_surface : '0);

  assign new_total   = (cur_total == COUNT_MAX) ? cur_total : cur_total + COUNT_BITS'(1);
  assign new_surface = (s1_surf && cur_surface != COUNT_MAX) ? cur_surface + COUNT_BITS'(1)
                                                             : cur_surface;
  assign mem_we = s1_valid && s1_count_en;

  assign k_is_last = ((LABEL_BITS+1)'(k) + (LABEL_BITS+1)'(1)) == n_eff;
  assign div_start = (state == ST_START);

  always_comb begin
    clear_all = 1'b0;
    case (state)
      ST_COUNT: clear_all = s1_valid && s1_last && (n_eff <= (LABEL_BITS+1)'(1));
      ST_OUT:   clear_all = out_valid && !out_stall && k_is_last;
      default:  clear_all = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label_count <= CFG_BITS'(MAX_LABELS);
    end else if (cfg_we) begin
      label_count <= cfg_data;
    end
  end

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      total_mem[s1_label]   <= new_total;
      surface_mem[s1_label] <= new_surface;
    end
    if (rd_en) begin
      rd_total   <= total_mem[rd_addr];
      rd_surface <= surface_mem[rd_addr];
    end
  end

  // A clear wins over a write-back in the same cycle.
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      vbits <= '0;
    end else if (mem_we) begin
      vbits[s1_label] <= 1'b1;
    end
  end

  // Read-side flags follow each memory read; the forwarding flag is only
  // set for the cycle straight after a voxel transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit    <= 1'b0;
      rd_vld <= 1'b0;
    end else begin
      hit <= in_accept && mem_we && (s1_label == in_data.feature_label);
      if (rd_en) begin
        rd_vld <= vbits[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_total   <= new_total;
    fwd_surface <= new_surface;
    if (in_accept) begin
      s1_label    <= in_data.feature_label;
      s1_surf     <= in_data.surface_mark > MARK_BITS'(0);
      s1_count_en <= {1'b0, in_data.feature_label} < n_eff;
      s1_last     <= in_data.last_voxel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
  end

  // Readout sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COUNT;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_COUNT: begin
          if (s1_valid && s1_last && !clear_all) begin
            state <= ST_READ;
          end
        end
        ST_READ:  state <= ST_START;
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (div_done) begin
            out_valid <= 1'b1;
            state     <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= k_is_last ? ST_COUNT : ST_READ;
          end
        end
        default: state <= ST_COUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_COUNT) begin
      k <= LABEL_BITS'(1);
    end else if (state == ST_OUT && !out_stall) begin
      k <= k + LABEL_BITS'(1);
    end
  end

  // The read data registers hold steady from the read until the result loads.
  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_done) begin
      out_data.label_index      <= k;
      out_data.surface_fraction <= (cur_total == '0) ? '0 : div_quotient;
      out_data.voxel_total      <= TOTAL_OUT_BITS'(cur_total);
      out_data.empty_label      <= (cur_total == '0);
      out_data.last_result      <= k_is_last;
    end
  end

  psf_frac_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (cur_surface),
    .den      (cur_total),
    .done     (div_done),
    .quotient (div_quotient)
  );

  `PSF_ASSERT_IMPL(a_accept_counting, clk, rst, in_accept, state == ST_COUNT)
  `PSF_ASSERT_IMPL(a_out_state, clk, rst, out_valid, state == ST_OUT)
  `PSF_ASSERT_IMPL(a_hit_stage, clk, rst, hit && state == ST_COUNT, s1_valid)
  `PSF_ASSERT_IMPL(a_surf_le_total, clk, rst, mem_we, cur_surface <= cur_total)
  `PSF_ASSERT_NEXT(a_clear_after, clk, rst,
                   out_valid && !out_stall && out_data.last_result, vbits == '0)

endmodule

>>> rtl/psf_frac_div.sv
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring divider giving floor(num * 2^FRACTION_BITS / den), one quotient
// bit per cycle, saturated at one when num is not below den.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psf_frac_div
  import psf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [COUNT_BITS-1:0]    num,
  input  logic [COUNT_BITS-1:0]    den,
  output logic                     done,
  output logic [FRAC_OUT_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(FRACTION_BITS);
  localparam logic [FRAC_OUT_BITS-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic                     busy;
  logic [STEP_BITS-1:0]     step;
  logic [COUNT_BITS-1:0]    rem;
  logic [COUNT_BITS-1:0]    den_reg;
  logic [FRACTION_BITS-2:0] quo;
  logic [COUNT_BITS:0]      rem_shift;
  logic                     take;
  logic                     last_step;

  assign rem_shift = {rem, 1'b0};
  assign take      = rem_shift >= {1'b0, den_reg};
  assign last_step = step == STEP_BITS'(FRACTION_BITS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= num < den;
      done <= num >= den;
    end else begin
      busy <= busy && !last_step;
      done <= busy && last_step;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num;
      den_reg <= den;
      step    <= '0;
      quo     <= '0;
      if (num >= den) begin
        quotient <= FRAC_ONE;
      end
    end else if (busy) begin
      rem  <= take ? COUNT_BITS'(rem_shift - {1'b0, den_reg}) : rem_shift[COUNT_BITS-1:0];
      quo  <= {quo[FRACTION_BITS-3:0], take};
      step <= step + STEP_BITS'(1);
      if (last_step) begin
        quotient <= {1'b0, quo, take};
      end
    end
  end

  `PSF_ASSERT_IMPL(a_start_idle, clk, rst, start, !busy)
  `PSF_ASSERT_IMPL(a_done_idle, clk, rst, done, !busy)
  `PSF_ASSERT_IMPL(a_quo_range, clk, rst, done, quotient <= FRAC_ONE)

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Surface fraction unit testbench
// Sends voxel streams through the unit under random sender gaps and result
// stalls, and holds a model of the per-label counts. Each
// readout transfer is checked field by field against the fractions that the
// model works out when the last voxel of a volume is accepted.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import psf_pkg::*;

  // Even if every voxel of the run ended a volume that reads out all 63 labels
  // with the longest stalls, this limit would still leave a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 2000000;
  // Cycles allowed for the unit to go quiet after the last result (or after
  // a readout that reports no labels at all).
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned RANDOM_VOXELS = 160;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_data;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_data;

  // Model state: the two count stores and the label count register.
  logic [COUNT_BITS-1:0] voxel_tally   [MAX_LABELS];
  logic [COUNT_BITS-1:0] surface_tally [MAX_LABELS];
  int unsigned           labels_in_use;

  // Fractions awaiting their result transfer, oldest first.
  out_item_t   pending_fractions [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  // When clear, neither the sender nor the receiver inserts any idle cycles.
  bit          gaps_on;

  per_label_surface_fraction_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The watchdog also ends a run that hangs on a handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Surface count over total count with 16 fraction bits, truncated. The
  // result saturates at one, and an empty label reads as zero rather than the
  // undefined quotient.
  function automatic logic [FRAC_OUT_BITS-1:0] fraction_of(
    logic [COUNT_BITS-1:0] surface,
    logic [COUNT_BITS-1:0] total
  );
    logic [COUNT_BITS+FRACTION_BITS-1:0] scaled;
    if (total == '0) return '0;
    if (surface >= total) return {1'b1, {FRACTION_BITS{1'b0}}};
    scaled = {surface, {FRACTION_BITS{1'b0}}};
    return FRAC_OUT_BITS'(scaled / total);
  endfunction

  // Counts one accepted voxel and, on the last voxel of a volume, queues one
  // fraction per reported label and clears both stores.
  function automatic void tally_voxel(in_item_t voxel);
    int unsigned active;
    int unsigned lbl;
    out_item_t   frac;
    active = (labels_in_use < MAX_LABELS) ? labels_in_use : MAX_LABELS;
    lbl    = 32'(voxel.feature_label);
    // Labels at or above the active count are dropped without trace.
    if (lbl < active) begin
      if (voxel_tally[lbl] != '1) voxel_tally[lbl]++;
      if ($signed(voxel.surface_mark) > 0 && surface_tally[lbl] != '1) begin
        surface_tally[lbl]++;
      end
    end
    if (voxel.last_voxel) begin
      // The background label is counted but never reported.
      for (int unsigned k = 1; k < active; k++) begin
        frac.label_index      = LABEL_BITS'(k);
        frac.surface_fraction = fraction_of(surface_tally[k], voxel_tally[k]);
        frac.voxel_total      = TOTAL_OUT_BITS'(voxel_tally[k]);
        frac.empty_label      = (voxel_tally[k] == '0);
        frac.last_result      = (k + 1 == active);
        pending_fractions.push_back(frac);
      end
      foreach (voxel_tally[k]) begin
        voxel_tally[k]   = '0;
        surface_tally[k] = '0;
      end
    end
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Every result transfer is compared with the oldest queued fraction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch($sformatf("unexpected result for label %0d",
                                  out_data.label_index));
      end else begin
        want = pending_fractions.pop_front();
        if (out_data.label_index !== want.label_index)
          report_mismatch($sformatf("label_index %0d, wanted %0d",
                                    out_data.label_index, want.label_index));
        if (out_data.surface_fraction !== want.surface_fraction)
          report_mismatch($sformatf("label %0d surface_fraction %0d, wanted %0d",
                                    want.label_index, out_data.surface_fraction,
                                    want.surface_fraction));
        if (out_data.voxel_total !== want.voxel_total)
          report_mismatch($sformatf("label %0d voxel_total %0d, wanted %0d",
                                    want.label_index, out_data.voxel_total,
                                    want.voxel_total));
        if (out_data.empty_label !== want.empty_label)
          report_mismatch($sformatf("label %0d empty_label %b, wanted %b",
                                    want.label_index, out_data.empty_label,
                                    want.empty_label));
        if (out_data.last_result !== want.last_result)
          report_mismatch($sformatf("label %0d last_result %b, wanted %b",
                                    want.label_index, out_data.last_result,
                                    want.last_result));
      end
    end
  end

  // The receiver holds off for a random number of cycles before each result
  // and then stays ready until that result has been transferred.
  initial begin : result_receiver
    int unsigned hold;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      hold = gaps_on ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one voxel after a random gap and returns at the clock edge that
  // transfers it. The valid stays high afterwards; the next send or a drain
  // decides at the following falling edge whether it drops.
  task automatic send_voxel(int unsigned lbl, int mark, bit last);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              = 1'b1;
    in_data.feature_label = LABEL_BITS'(lbl);
    in_data.surface_mark  = MARK_BITS'(mark);
    in_data.last_voxel    = last;
    do @(posedge clk); while (in_stall);
    tally_voxel(in_data);
  endtask

  // Stops sending and waits until every queued fraction has arrived, then
  // gives the unit time to finish any readout that reports nothing.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_fractions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the unit is idle.
  task automatic set_label_count(int unsigned value);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = CFG_BITS'(value);
    @(posedge clk);
    labels_in_use = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // The reset value of the label count reports all 63 labels, most of them
  // empty. The marks cover both extremes and the zero boundary.
  task automatic test_reset_count();
    send_voxel(0, 127, 1'b0);
    send_voxel(63, -128, 1'b0);
    send_voxel(63, 1, 1'b0);
    send_voxel(1, 0, 1'b0);
    send_voxel(1, -1, 1'b0);
    send_voxel(2, 127, 1'b1);
    wait_drained();
  endtask

  // Smallest counts and labels beyond the active range. A last voxel with an
  // ignored label still triggers the readout.
  task automatic test_label_limits();
    set_label_count(1);
    send_voxel(0, 5, 1'b0);
    send_voxel(3, 7, 1'b1);
    wait_drained();
    set_label_count(2);
    send_voxel(1, 1, 1'b0);
    send_voxel(0, 1, 1'b1);
    wait_drained();
    set_label_count(5);
    send_voxel(5, 1, 1'b0);
    send_voxel(63, 1, 1'b0);
    send_voxel(4, -3, 1'b0);
    send_voxel(60, 1, 1'b1);
    wait_drained();
    set_label_count(64);
    wait_drained();
  endtask

  // Thirds exercise the truncation, and back-to-back transfers on one label
  // exercise the forwarding between successive voxels.
  task automatic test_fraction_floor();
    gaps_on = 1'b0;
    set_label_count(8);
    send_voxel(1, 9, 1'b0);
    send_voxel(1, 0, 1'b0);
    send_voxel(1, -9, 1'b0);
    send_voxel(7, 100, 1'b0);
    send_voxel(7, -100, 1'b0);
    send_voxel(7, 3, 1'b1);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Random volumes with random marks. Most labels fall in the active range;
  // the rest anywhere, and those beyond it are noise the unit must ignore.
  // Label counts change between volumes; the sender sometimes pauses to drain.
  task automatic test_random_volumes();
    int unsigned counted;
    int unsigned active;
    int unsigned length;
    int unsigned lbl;
    counted = 0;
    active  = labels_in_use;
    while (counted < RANDOM_VOXELS) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_drained();
        case ($urandom_range(0, 9))
          0:       active = 1;
          1, 2:    active = 64;
          3, 4:    active = $urandom_range(7, 63);
          default: active = $urandom_range(2, 6);
        endcase
        set_label_count(active);
      end else if ($urandom_range(0, 3) == 0) begin
        wait_drained();
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      length  = $urandom_range(1, 16);
      for (int unsigned v = 0; v < length; v++) begin
        if ($urandom_range(0, 6) == 0) lbl = $urandom_range(0, 63);
        else lbl = $urandom_range(0, active - 1);
        if (lbl < active) counted++;
        send_voxel(lbl, $urandom_range(0, 255), v + 1 == length);
      end
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // Short volumes whose last voxels follow one another with no idle cycles
  // on either side, so a new volume starts as soon as a readout ends.
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    set_label_count(3);
    for (int unsigned v = 0; v < 20; v++) begin
      send_voxel($urandom_range(0, 2), $urandom_range(0, 255), v[0]);
    end
    wait_drained();
    gaps_on = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    gaps_on       = 1'b1;
    mismatches    = 0;
    cycle_count   = 0;
    labels_in_use = 64;
    foreach (voxel_tally[k]) begin
      voxel_tally[k]   = '0;
      surface_tally[k] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_count();
    test_label_limits();
    test_fraction_floor();
    test_random_volumes();
    test_back_to_back();
    wait_drained();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
